>>> rtl/sfpa_pkg.sv
// Shared types and constants of the stack frame pool allocator.
// No dependencies; the interfaces, the divider and the top level import this package.
package sfpa_pkg;

	// Field and register widths.
	localparam int ADDR_W     = 48;
	localparam int SIZE_W     = 25;
	localparam int SHIFT_W    = 5;
	localparam int COUNT_W    = 11;
	localparam int FIDX_W     = 10;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	// Page size range and the widths that follow from it.
	localparam logic [SHIFT_W-1:0] MIN_SHIFT = 5'd12;
	localparam logic [SHIFT_W-1:0] MAX_SHIFT = 5'd21;
	localparam int PAGE_W = 22;
	// Frame stride in pages: at most 1 + ceil((2^25 - 1) / 2^12) = 8193.
	localparam int K_W    = 14;

	// Low address bits that are always cleared on an allocated address.
	localparam logic [63:0] TAG_CLEAR = ~64'd3;

	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_EMPTY    = 3'd1;
	localparam status_t ST_MISALIGN = 3'd2;
	localparam status_t ST_BELOW    = 3'd3;
	localparam status_t ST_BEYOND   = 3'd4;
	localparam status_t ST_DOUBLE   = 3'd5;

	localparam cfg_idx_t REG_POOL_BASE  = 2'd0;
	localparam cfg_idx_t REG_PAGE_SHIFT = 2'd1;
	localparam cfg_idx_t REG_FRAME_SIZE = 2'd2;
	localparam cfg_idx_t REG_FRAME_CNT  = 2'd3;

	localparam logic [ADDR_W-1:0]  RST_POOL_BASE  = '0;
	localparam logic [SHIFT_W-1:0] RST_PAGE_SHIFT = 5'd12;
	localparam logic [SIZE_W-1:0]  RST_FRAME_SIZE = 25'd8192;
	localparam logic [COUNT_W-1:0] RST_FRAME_CNT  = 11'd1024;

	// Handshake between the top level and the divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/sfpa_req_if.sv
// Request channel of the stack frame pool allocator: operation and address.
// Depends on sfpa_pkg for the field widths.
interface sfpa_req_if import sfpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [ADDR_W-1:0] free_address;

	modport source (output valid, output op, output free_address, input ready);
	modport sink (input valid, input op, input free_address, output ready);
endinterface

>>> rtl/sfpa_rsp_if.sv
// Response channel of the stack frame pool allocator.
// Depends on sfpa_pkg for the field widths and the status type.
interface sfpa_rsp_if import sfpa_pkg::*; ();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [ADDR_W-1:0] frame_address;
	logic [SIZE_W-1:0] frame_size;
	logic [FIDX_W-1:0] frame_index;

	modport source (output valid, output status, output frame_address, output frame_size,
		output frame_index, input ready);
	modport sink (input valid, input status, input frame_address, input frame_size,
		input frame_index, output ready);
endinterface

>>> rtl/sfpa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module sfpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/sfpa_div.sv
// Restoring divider, one quotient bit per cycle, for the frame index lookup.
// Depends on sfpa_pkg for the status struct.
module sfpa_div import sfpa_pkg::*; #(
	parameter int Q_W = 10,
	parameter int D_W = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [Q_W+D_W-1:0] dividend,
	input  logic [D_W-1:0]     divisor,
	output logic [Q_W-1:0]     quotient,
	output div_stat_t          stat
);
	localparam int CNT_W = $clog2(Q_W + 1);

	// The caller guarantees dividend < divisor * 2^Q_W, so the upper part
	// starts out as a valid partial remainder.
	logic [D_W-1:0]   rem_q;
	logic [Q_W-1:0]   quo_q;
	logic [D_W-1:0]   div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     trial;
	logic             fits;

	assign trial = {rem_q, quo_q[Q_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[Q_W+D_W-1:Q_W];
			quo_q <= dividend[Q_W-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? D_W'(trial - {1'b0, div_q}) : trial[D_W-1:0];
			quo_q <= (quo_q << 1) | Q_W'(fits);
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

>>> rtl/stack_frame_pool_allocator.sv
// Top level of the stack frame pool allocator: sequencer, free stack, used marks.
// Depends on sfpa_pkg, sfpa_req_if, sfpa_rsp_if, sfpa_ram and sfpa_div.
//
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    op, free_address
// rsp       out  valid/ready    status, frame_address, frame_size, frame_index
// cfg       in   cfg_we only    cfg_index, cfg_wdata
//
// One request is processed at a time, from S_SETUP to S_DONE. An allocate runs
// S_A_SEL, S_A_POP for a popped frame, S_A_MARK, S_A_SHIFT and S_A_SUM, or only
// S_A_SEL if the pool is empty. A free runs S_F_ALIGN, S_F_BASE, S_F_LIMIT,
// S_F_DIV, where the bit-serial divider maps the offset to a frame index, and
// S_F_MARK; a rejected free drops out at S_F_ALIGN, S_F_BASE or S_F_LIMIT. The
// response register lets the next request be accepted while a response is still
// waiting on rsp.ready. Reset, and any configuration write, empty the free stack
// and the fresh-frame counter; the used marks need no clearing pass.
module stack_frame_pool_allocator import sfpa_pkg::*; #(
	parameter int POOL_FRAMES = 1024,
	parameter int ADDR_BITS   = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sfpa_req_if.sink              req,
	sfpa_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	localparam int IDX_W  = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
	localparam int CNT_W  = $clog2(POOL_FRAMES + 1);
	localparam int PROD_W = IDX_W + K_W;
	localparam int LIM_W  = CNT_W + K_W;
	localparam logic [ADDR_BITS-1:0] TAG_MASK = ADDR_BITS'(TAG_CLEAR);

	// Sequencer states.
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SETUP   = 4'd1;
	localparam logic [3:0] S_A_SEL   = 4'd2;
	localparam logic [3:0] S_A_POP   = 4'd3;
	localparam logic [3:0] S_A_MARK  = 4'd4;
	localparam logic [3:0] S_A_SHIFT = 4'd5;
	localparam logic [3:0] S_A_SUM   = 4'd6;
	localparam logic [3:0] S_F_ALIGN = 4'd7;
	localparam logic [3:0] S_F_BASE  = 4'd8;
	localparam logic [3:0] S_F_LIMIT = 4'd9;
	localparam logic [3:0] S_F_DIV   = 4'd10;
	localparam logic [3:0] S_F_MARK  = 4'd11;
	localparam logic [3:0] S_DONE    = 4'd12;

	// Configuration registers.
	logic [ADDR_W-1:0]  cfg_base_q;
	logic [SHIFT_W-1:0] cfg_shift_q;
	logic [SIZE_W-1:0]  cfg_size_q;
	logic [COUNT_W-1:0] cfg_count_q;

	// Control state.
	logic [3:0]       state_q;
	logic [CNT_W-1:0] freed_depth_q;
	logic [CNT_W-1:0] next_fresh_q;
	logic             out_valid_q;

	// Request and derived geometry, captured per request.
	logic                 op_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [SHIFT_W-1:0]   shift_q;
	logic [PAGE_W-1:0]    page_q;
	logic [K_W-1:0]       k_q;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_BITS-1:0] base_page_q;
	logic [IDX_W-1:0]     idx_q;
	logic [PROD_W-1:0]    prod_q;
	logic [ADDR_BITS-1:0] off_q;
	logic [LIM_W-1:0]     limit_q;
	logic [ADDR_W:0]      diff_q;
	logic [ADDR_W-1:0]    pages_q;

	// Result being built, and the response register.
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_faddr_q;
	logic [SIZE_W-1:0] res_fsize_q;
	logic [FIDX_W-1:0] res_fidx_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_faddr_q;
	logic [SIZE_W-1:0] out_fsize_q;
	logic [FIDX_W-1:0] out_fidx_q;

	// Combinational helpers.
	logic [SHIFT_W-1:0] shift_c;
	logic [PAGE_W-1:0]  page_c;
	logic [SIZE_W:0]    ksum_c;
	logic [K_W-1:0]     k_c;
	logic [CNT_W-1:0]   count_c;
	logic               accept;
	logic               misaligned;
	logic               below_base;
	logic               beyond;
	logic               load_out;
	logic               used;
	logic [CNT_W-1:0]   depth_m1;

	// Memories and divider.
	logic             stack_we;
	logic [IDX_W-1:0] stack_rdata;
	logic             mark_we;
	logic             mark_wdata;
	logic             mark_rdata;
	logic             div_start;
	logic [IDX_W-1:0] div_quo;
	div_stat_t        div_stat;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// The page size is clamped to the supported range; the stride is a whole
	// number of pages, one guard page plus the usable size rounded up.
	always_comb begin
		if (cfg_shift_q < MIN_SHIFT) begin
			shift_c = MIN_SHIFT;
		end else if (cfg_shift_q > MAX_SHIFT) begin
			shift_c = MAX_SHIFT;
		end else begin
			shift_c = cfg_shift_q;
		end
		page_c = PAGE_W'(1) << shift_c;
		ksum_c = (SIZE_W+1)'(cfg_size_q) + (SIZE_W+1)'(page_c) - (SIZE_W+1)'(1);
		k_c    = K_W'(ksum_c >> shift_c) + K_W'(1);
		if (32'(cfg_count_q) > 32'(POOL_FRAMES)) begin
			count_c = CNT_W'(POOL_FRAMES);
		end else begin
			count_c = CNT_W'(cfg_count_q);
		end
	end

	assign misaligned = |(addr_q[PAGE_W-1:0] & (page_q - PAGE_W'(1)));
	assign below_base = diff_q[ADDR_W] || (diff_q[ADDR_W-1:0] < cfg_base_q);
	assign beyond     = pages_q >= ADDR_W'(limit_q);
	assign depth_m1   = freed_depth_q - CNT_W'(1);

	// A used mark is only meaningful below the fresh-frame counter: frames at or
	// above it have never been handed out since the last restart.
	assign used = mark_rdata && (CNT_W'(idx_q) < next_fresh_q);

	assign stack_we   = (state_q == S_F_MARK) && used &&
		(freed_depth_q < CNT_W'(POOL_FRAMES));
	assign mark_we    = (state_q == S_A_MARK) || ((state_q == S_F_MARK) && used);
	assign mark_wdata = (state_q == S_A_MARK);
	assign div_start  = (state_q == S_F_LIMIT) && !beyond;

	sfpa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (POOL_FRAMES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (freed_depth_q[IDX_W-1:0]),
		.wdata (idx_q),
		.raddr (depth_m1[IDX_W-1:0]),
		.rdata (stack_rdata)
	);

	sfpa_ram #(
		.WIDTH (1),
		.DEPTH (POOL_FRAMES)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (idx_q),
		.wdata (mark_wdata),
		.raddr (div_quo),
		.rdata (mark_rdata)
	);

	sfpa_div #(
		.Q_W (IDX_W),
		.D_W (K_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pages_q[PROD_W-1:0]),
		.divisor  (k_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Configuration registers; the user must write only while idle (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_base_q  <= RST_POOL_BASE;
			cfg_shift_q <= RST_PAGE_SHIFT;
			cfg_size_q  <= RST_FRAME_SIZE;
			cfg_count_q <= RST_FRAME_CNT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POOL_BASE:  cfg_base_q  <= cfg_wdata[ADDR_W-1:0];
				REG_PAGE_SHIFT: cfg_shift_q <= cfg_wdata[SHIFT_W-1:0];
				REG_FRAME_SIZE: cfg_size_q  <= cfg_wdata[SIZE_W-1:0];
				REG_FRAME_CNT:  cfg_count_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					state_q <= op_q ? S_F_ALIGN : S_A_SEL;
				end
				S_A_SEL: begin
					// Most recently freed frame first, then the next fresh one.
					if (freed_depth_q != '0) begin
						state_q <= S_A_POP;
					end else if (next_fresh_q < count_q) begin
						state_q <= S_A_MARK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_A_POP:   state_q <= S_A_MARK;
				S_A_MARK:  state_q <= S_A_SHIFT;
				S_A_SHIFT: state_q <= S_A_SUM;
				S_A_SUM:   state_q <= S_DONE;
				S_F_ALIGN: state_q <= misaligned ? S_DONE : S_F_BASE;
				S_F_BASE:  state_q <= below_base ? S_DONE : S_F_LIMIT;
				S_F_LIMIT: state_q <= beyond ? S_DONE : S_F_DIV;
				S_F_DIV: begin
					if (div_stat.done) begin
						state_q <= S_F_MARK;
					end
				end
				S_F_MARK:  state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Free stack depth and fresh-frame counter. A configuration write restarts
	// the pool with every frame free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freed_depth_q <= '0;
			next_fresh_q  <= '0;
		end else if (cfg_we) begin
			freed_depth_q <= '0;
			next_fresh_q  <= '0;
		end else begin
			if ((state_q == S_A_SEL) && (freed_depth_q != '0)) begin
				freed_depth_q <= depth_m1;
			end else if (stack_we) begin
				freed_depth_q <= freed_depth_q + CNT_W'(1);
			end
			if ((state_q == S_A_SEL) && (freed_depth_q == '0) && (next_fresh_q < count_q)) begin
				next_fresh_q <= next_fresh_q + CNT_W'(1);
			end
		end
	end

	// Response valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= req.op;
					addr_q       <= req.free_address;
					res_status_q <= ST_OK;
					res_faddr_q  <= '0;
					res_fsize_q  <= '0;
					res_fidx_q   <= '0;
				end
			end
			S_SETUP: begin
				shift_q     <= shift_c;
				page_q      <= page_c;
				k_q         <= k_c;
				count_q     <= count_c;
				base_page_q <= ADDR_BITS'(cfg_base_q) + ADDR_BITS'(page_c);
			end
			S_A_SEL: begin
				if (freed_depth_q == '0) begin
					if (next_fresh_q < count_q) begin
						idx_q <= next_fresh_q[IDX_W-1:0];
					end else begin
						res_status_q <= ST_EMPTY;
					end
				end
			end
			S_A_POP:   idx_q  <= stack_rdata;
			S_A_MARK:  prod_q <= PROD_W'(idx_q) * PROD_W'(k_q);
			S_A_SHIFT: off_q  <= ADDR_BITS'(prod_q) << shift_q;
			S_A_SUM: begin
				// The usable area starts one guard page into the frame.
				res_faddr_q <= ADDR_W'((base_page_q + off_q) & TAG_MASK);
				res_fsize_q <= cfg_size_q;
				res_fidx_q  <= FIDX_W'(idx_q);
			end
			S_F_ALIGN: begin
				limit_q <= LIM_W'(count_q) * LIM_W'(k_q);
				diff_q  <= (ADDR_W+1)'(addr_q) - (ADDR_W+1)'(page_q);
				if (misaligned) begin
					res_status_q <= ST_MISALIGN;
				end
			end
			S_F_BASE: begin
				// Offset from the base in whole pages; the stride in pages then
				// divides it down to the frame index.
				pages_q <= (diff_q[ADDR_W-1:0] - cfg_base_q) >> shift_q;
				if (below_base) begin
					res_status_q <= ST_BELOW;
				end
			end
			S_F_LIMIT: begin
				if (beyond) begin
					res_status_q <= ST_BEYOND;
				end
			end
			S_F_DIV: begin
				if (div_stat.done) begin
					idx_q <= div_quo;
				end
			end
			S_F_MARK: begin
				res_fidx_q <= FIDX_W'(idx_q);
				if (!used) begin
					res_status_q <= ST_DOUBLE;
				end
			end
			S_DONE: begin
				if (load_out) begin
					out_status_q <= res_status_q;
					out_faddr_q  <= res_faddr_q;
					out_fsize_q  <= res_fsize_q;
					out_fidx_q   <= res_fidx_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.frame_address = out_faddr_q;
	assign rsp.frame_size    = out_fsize_q;
	assign rsp.frame_index   = out_fidx_q;

`ifndef SYNTHESIS
	// Every frame on the free stack was handed out fresh once, and only once.
	a_depth_le_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		freed_depth_q <= next_fresh_q)
		else $error("free stack deeper than the number of frames ever handed out");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_fresh_q <= CNT_W'(POOL_FRAMES))
		else $error("fresh-frame counter ran past the pool");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.frame_address == '0 &&
		rsp.frame_size == '0))
		else $error("failed request returned a nonzero address or size");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_F_DIV))
		else $error("divider finished outside the index lookup");
`endif
endmodule
